// ===== hw/rtl/bbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbp_pkg
// Shared types and constants of the bicubic bezier patch evaluator.
// ----------------------------------------------------------------------------
package bbp_pkg;

  localparam int unsigned GridDim      = 4;
  localparam int unsigned GridEntries  = GridDim * GridDim;
  localparam int unsigned DeriveSteps  = 15;
  localparam int unsigned WeightSteps  = 12;
  localparam int unsigned StepsPerSide = 6;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DERIVE,
    ST_WEIGHT,
    ST_MAC,
    ST_FINAL
  } state_e;

  typedef enum logic [1:0] {
    DK_PRE,
    DK_LOW,
    DK_UPP
  } derive_kind_e;

  typedef struct packed {
    derive_kind_e kind;
    logic [3:0]   rd;
    logic [3:0]   wr;
  } derive_step_t;

  // z derivation sweep: per row a preload of the diagonal z into both chains,
  // then lower and upper chain steps alternating
  function automatic derive_step_t derive_step(input logic [3:0] s);
    derive_step_t d;
    d = '{kind: DK_PRE, rd: 4'd0, wr: 4'd0};
    case (s)
      4'd0:  d = '{kind: DK_PRE, rd: 4'd5,  wr: 4'd0};
      4'd1:  d = '{kind: DK_LOW, rd: 4'd0,  wr: 4'd4};
      4'd2:  d = '{kind: DK_UPP, rd: 4'd0,  wr: 4'd1};
      4'd3:  d = '{kind: DK_PRE, rd: 4'd10, wr: 4'd0};
      4'd4:  d = '{kind: DK_LOW, rd: 4'd5,  wr: 4'd9};
      4'd5:  d = '{kind: DK_UPP, rd: 4'd5,  wr: 4'd6};
      4'd6:  d = '{kind: DK_LOW, rd: 4'd4,  wr: 4'd8};
      4'd7:  d = '{kind: DK_UPP, rd: 4'd1,  wr: 4'd2};
      4'd8:  d = '{kind: DK_PRE, rd: 4'd15, wr: 4'd0};
      4'd9:  d = '{kind: DK_LOW, rd: 4'd10, wr: 4'd14};
      4'd10: d = '{kind: DK_UPP, rd: 4'd10, wr: 4'd11};
      4'd11: d = '{kind: DK_LOW, rd: 4'd9,  wr: 4'd13};
      4'd12: d = '{kind: DK_UPP, rd: 4'd6,  wr: 4'd7};
      4'd13: d = '{kind: DK_LOW, rd: 4'd8,  wr: 4'd12};
      4'd14: d = '{kind: DK_UPP, rd: 4'd2,  wr: 4'd3};
      default: d = '{kind: DK_PRE, rd: 4'd0, wr: 4'd0};
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/bbp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbp_if
// Request and response channels of the bezier patch evaluator.
// ----------------------------------------------------------------------------
interface bbp_req_if #(
  parameter int unsigned PARAM_FRAC_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [1:0]                 point_index;
  logic signed [31:0]         coord_x;
  logic signed [31:0]         coord_y;
  logic signed [31:0]         coord_z;
  logic [PARAM_FRAC_BITS:0]   param_u;
  logic [PARAM_FRAC_BITS:0]   param_v;

  modport source (output valid, req_type, point_index, coord_x, coord_y, coord_z,
                  param_u, param_v, input ready);
  modport sink   (input valid, req_type, point_index, coord_x, coord_y, coord_z,
                  param_u, param_v, output ready);
endinterface

interface bbp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== hw/rtl/bbp_wmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbp_wmul
// Shared weight multiplier with round-to-nearest back to the parameter format.
// ----------------------------------------------------------------------------
module bbp_wmul #(
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic [PARAM_FRAC_BITS+2:0] a_i,
  input  logic [PARAM_FRAC_BITS:0]   b_i,
  output logic [PARAM_FRAC_BITS:0]   p_o
);
  localparam int unsigned PW = 2 * PARAM_FRAC_BITS + 4;

  logic [PW-1:0] prod;
  logic [PW-1:0] rsum;

  assign prod = PW'(a_i) * PW'(b_i);
  assign rsum = prod + (PW'(1) << (PARAM_FRAC_BITS - 1));
  assign p_o  = rsum[2*PARAM_FRAC_BITS:PARAM_FRAC_BITS];
endmodule

// ===== hw/rtl/bicubic_bezier_patch_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval
// Bicubic bezier patch: diagonal point loads and surface evaluation.
// ----------------------------------------------------------------------------
// A load request is accepted and then runs a 15-step sweep that derives the
// off-diagonal z values through one averaging adder. An evaluate request runs
// 12 steps of cubic weights through one shared multiplier, then a sweep in which
// the 16 grid entries pass one per cycle through the same multiplier, which forms
// the pair weights, and three multiply-accumulate lanes, then a final step of
// rounding and saturation that waits for a free output register. The block takes one request at a time; a finished
// result waits in the output register while the next request is accepted.
module bicubic_bezier_patch_eval #(
  parameter int unsigned PARAM_FRAC_BITS = 16,
  parameter int unsigned COORD_WIDTH     = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbp_req_if.sink   req_i,
  bbp_rsp_if.source rsp_o
);
  import bbp_pkg::*;

  localparam int unsigned F   = PARAM_FRAC_BITS;
  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned AW  = CW + F + 6;
  localparam int unsigned RW  = AW - F;
  localparam int unsigned SW  = (CW < 32) ? CW : 32;
  localparam int unsigned IW  = (CW > 32) ? CW : 32;

  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  logic signed [CW-1:0] dx_q [GridDim];
  logic signed [CW-1:0] dy_q [GridDim];
  logic signed [CW-1:0] gz_q [GridEntries];
  logic signed [CW-1:0] run_l_q, run_u_q;

  logic [F:0] pu_q, pv_q;
  logic [F:0] p2_q, t2_q;
  logic [F:0] wu_q [GridDim];
  logic [F:0] wv_q [GridDim];
  logic [F:0] pw_q;
  logic [3:0] ent_q;
  logic       mac_vld_q;

  logic signed [AW-1:0] acc_x_q, acc_y_q, acc_z_q;
  logic                 out_vld_q;
  logic signed [31:0]   out_x_q, out_y_q, out_z_q;

  function automatic logic signed [CW-1:0] sat_load(input logic signed [31:0] v);
    logic signed [IW-1:0] ext;
    logic signed [IW-1:0] hi;
    logic signed [IW-1:0] lo;
    ext = IW'(v);
    hi  = {{(IW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo  = ~hi;
    if (ext > hi) begin
      ext = hi;
    end else if (ext < lo) begin
      ext = lo;
    end
    return ext[CW-1:0];
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [RW-1:0] r);
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    logic signed [RW-1:0] s;
    hi = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    lo = ~hi;
    s  = r;
    if (r > hi) begin
      s = hi;
    end else if (r < lo) begin
      s = lo;
    end
    return {{(33-SW){s[SW-1]}}, s[SW-2:0]};
  endfunction

  // control
  logic         req_acc;
  logic         fin_ok;
  derive_step_t dstep;
  logic         wside;
  logic [3:0]   wsub;

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign fin_ok      = !out_vld_q || rsp_o.ready;
  assign dstep       = derive_step(cnt_q[3:0]);
  assign wside       = (cnt_q >= 5'(StepsPerSide));
  assign wsub        = wside ? (cnt_q[3:0] - 4'(StepsPerSide)) : cnt_q[3:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (req_acc) begin
          state_d = (req_i.req_type == REQ_EVAL) ? ST_WEIGHT : ST_DERIVE;
        end
      end
      ST_DERIVE: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DeriveSteps - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_WEIGHT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(WeightSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(GridEntries)) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (fin_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // grid: diagonal x and y, full z
  logic signed [CW-1:0] z_rd;
  logic signed [CW-1:0] z_chain;
  logic signed [CW:0]   z_sum;
  logic signed [CW-1:0] z_mean;

  assign z_rd    = gz_q[dstep.rd];
  assign z_chain = (dstep.kind == DK_LOW) ? run_l_q : run_u_q;
  assign z_sum   = (CW+1)'(z_rd) + (CW+1)'(z_chain);
  assign z_mean  = z_sum[CW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GridDim; i++) begin
        dx_q[i] <= '0;
        dy_q[i] <= '0;
      end
      for (int i = 0; i < GridEntries; i++) begin
        gz_q[i] <= '0;
      end
    end else if (state_q == ST_IDLE && req_acc && req_i.req_type == REQ_LOAD) begin
      dx_q[req_i.point_index] <= sat_load(req_i.coord_x);
      dy_q[req_i.point_index] <= sat_load(req_i.coord_y);
      gz_q[{req_i.point_index, req_i.point_index}] <= sat_load(req_i.coord_z);
    end else if (state_q == ST_DERIVE && dstep.kind != DK_PRE) begin
      gz_q[dstep.wr] <= z_mean;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DERIVE) begin
      case (dstep.kind)
        DK_PRE: begin
          run_l_q <= z_rd;
          run_u_q <= z_rd;
        end
        DK_LOW: run_l_q <= z_mean;
        DK_UPP: run_u_q <= z_mean;
        default: ;
      endcase
    end
  end

  // shared weight multiplier
  logic [F:0]   pc;
  logic [F:0]   tc;
  logic [F+2:0] mul_a;
  logic [F:0]   mul_b;
  logic [F:0]   mul_p;

  assign pc = wside ? ((pv_q > ONE) ? ONE : pv_q) : ((pu_q > ONE) ? ONE : pu_q);
  assign tc = ONE - pc;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_MAC) begin
      mul_a = (F+3)'(wu_q[cnt_q[3:2]]);
      mul_b = wv_q[cnt_q[1:0]];
    end else begin
      case (wsub)
        4'd0: begin mul_a = (F+3)'(pc); mul_b = pc; end
        4'd1: begin mul_a = (F+3)'(tc); mul_b = tc; end
        4'd2: begin mul_a = (F+3)'(t2_q); mul_b = tc; end
        4'd3: begin mul_a = (F+3)'(pc) + ((F+3)'(pc) << 1); mul_b = t2_q; end
        4'd4: begin mul_a = (F+3)'(p2_q) + ((F+3)'(p2_q) << 1); mul_b = tc; end
        4'd5: begin mul_a = (F+3)'(p2_q); mul_b = pc; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  bbp_wmul #(
    .PARAM_FRAC_BITS(F)
  ) u_wmul (
    .a_i(mul_a),
    .b_i(mul_b),
    .p_o(mul_p)
  );

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      pu_q <= req_i.param_u;
      pv_q <= req_i.param_v;
    end
    if (state_q == ST_WEIGHT) begin
      case (wsub)
        4'd0: p2_q <= mul_p;
        4'd1: t2_q <= mul_p;
        4'd2, 4'd3, 4'd4, 4'd5: begin
          if (wside) begin
            wv_q[wsub[1:0] - 2'd2] <= mul_p;
          end else begin
            wu_q[wsub[1:0] - 2'd2] <= mul_p;
          end
        end
        default: ;
      endcase
    end
    if (state_q == ST_MAC) begin
      pw_q  <= mul_p;
      ent_q <= cnt_q[3:0];
    end
  end

  // multiply-accumulate lanes, one grid entry per cycle
  logic signed [CW+F+1:0] prod_x, prod_y, prod_z;
  logic signed [F+1:0]    pw_s;
  logic signed [AW-1:0]   half;
  logic signed [AW-1:0]   rx, ry, rz;

  assign pw_s   = $signed({1'b0, pw_q});
  assign prod_x = dx_q[ent_q[1:0]] * pw_s;
  assign prod_y = dy_q[ent_q[3:2]] * pw_s;
  assign prod_z = gz_q[ent_q] * pw_s;
  assign half   = AW'(1) << (F - 1);
  assign rx     = acc_x_q + half;
  assign ry     = acc_y_q + half;
  assign rz     = acc_z_q + half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_vld_q <= 1'b0;
    end else begin
      mac_vld_q <= (state_q == ST_MAC) && (cnt_q < 5'(GridEntries));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WEIGHT) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_z_q <= '0;
    end else if (mac_vld_q) begin
      acc_x_q <= acc_x_q + AW'(prod_x);
      acc_y_q <= acc_y_q + AW'(prod_y);
      acc_z_q <= acc_z_q + AW'(prod_z);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_FINAL && fin_ok) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINAL && fin_ok) begin
      out_x_q <= sat_out(rx[AW-1:F]);
      out_y_q <= sat_out(ry[AW-1:F]);
      out_z_q <= sat_out(rz[AW-1:F]);
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.pos_x = out_x_q;
  assign rsp_o.pos_y = out_y_q;
  assign rsp_o.pos_z = out_z_q;

  a_mac_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_vld_q |-> state_q == ST_MAC)
    else $error("accumulate outside the entry sweep");

  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FINAL))
    else $error("result appeared without a final step");

  a_derive_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DERIVE |-> cnt_q < 5'(DeriveSteps))
    else $error("derive sweep overran");

endmodule

// ===== verif/bbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbp_checker
// Watches the request and response channels of the bezier patch evaluator.
// Keeps its own copy of the control grid, predicts every surface point and
// compares each response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bbp_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  bbp_req_if    req_i,
  bbp_rsp_if    rsp_i,
  output int    fail_cnt_o,
  output int    pending_cnt_o
);
  import bbp_pkg::*;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } surf_point_t;

  localparam longint FracOne  = 64'sd65536;
  localparam longint HalfLsb  = 64'sd32768;

  longint      grid_x[4][4];
  longint      grid_y[4][4];
  longint      grid_z[4][4];
  surf_point_t surface_pts_q[$];
  int          fail_cnt;

  assign fail_cnt_o    = fail_cnt;
  assign pending_cnt_o = surface_pts_q.size();

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rnd_q(input longint p);
    return (p + HalfLsb) >>> 16;
  endfunction

  // off-diagonal entries follow the diagonal; z is the floor of the mean
  task automatic rebuild_grid();
    for (int r = 0; r < 4; r++) begin
      for (int k = 1; k <= r; k++) begin
        grid_x[r][r-k] = grid_x[r-1][r-k];
        grid_y[r][r-k] = grid_y[r][r-k+1];
        grid_z[r][r-k] = (grid_z[r-1][r-k] + grid_z[r][r-k+1]) >>> 1;
        grid_x[r-k][r] = grid_x[r-k+1][r];
        grid_y[r-k][r] = grid_y[r-k][r-1];
        grid_z[r-k][r] = (grid_z[r-k+1][r] + grid_z[r-k][r-1]) >>> 1;
      end
    end
  endtask

  task automatic bern_weights(input logic [16:0] par, output longint w[4]);
    longint u, t, u2, t2;
    u = par;
    if (u > FracOne) u = FracOne;
    t  = FracOne - u;
    u2 = rnd_q(u * u);
    t2 = rnd_q(t * t);
    w[0] = rnd_q(t2 * t);
    w[1] = rnd_q(3 * u * t2);
    w[2] = rnd_q(3 * u2 * t);
    w[3] = rnd_q(u2 * u);
  endtask

  function automatic logic signed [31:0] patch_coord(input longint g[4][4],
                                                     input longint wu[4],
                                                     input longint wv[4]);
    longint acc;
    acc = 0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        acc += rnd_q(wu[i] * wv[j]) * g[i][j];
    return 32'(clamp32(rnd_q(acc)));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint      wu[4];
    longint      wv[4];
    surf_point_t pt;
    surf_point_t exp_pt;
    int          p;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++) begin
          grid_x[i][j] = 0;
          grid_y[i][j] = 0;
          grid_z[i][j] = 0;
        end
      surface_pts_q.delete();
      fail_cnt = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        pt.x = rsp_i.pos_x;
        pt.y = rsp_i.pos_y;
        pt.z = rsp_i.pos_z;
        if (surface_pts_q.size() == 0) begin
          $display("%0t: unexpected response x=%0d y=%0d z=%0d", $time, pt.x, pt.y, pt.z);
          fail_cnt++;
        end else begin
          exp_pt = surface_pts_q.pop_front();
          if (pt.x !== exp_pt.x) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, exp_pt.x, pt.x);
            fail_cnt++;
          end
          if (pt.y !== exp_pt.y) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, exp_pt.y, pt.y);
            fail_cnt++;
          end
          if (pt.z !== exp_pt.z) begin
            $display("%0t: pos_z expected %0d actual %0d", $time, exp_pt.z, pt.z);
            fail_cnt++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.req_type == REQ_LOAD) begin
          p = req_i.point_index;
          grid_x[p][p] = req_i.coord_x;
          grid_y[p][p] = req_i.coord_y;
          grid_z[p][p] = req_i.coord_z;
          rebuild_grid();
        end else begin
          bern_weights(req_i.param_u, wu);
          bern_weights(req_i.param_v, wv);
          exp_pt.x = patch_coord(grid_x, wu, wv);
          exp_pt.y = patch_coord(grid_y, wu, wv);
          exp_pt.z = patch_coord(grid_z, wu, wv);
          surface_pts_q.insert(surface_pts_q.size(), exp_pt);
        end
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the bicubic bezier patch evaluator: directed corner requests,
// then random loads and evaluations with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import bbp_pkg::*;

  localparam int NumRandom = 1880;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending_cnt;
  int   rsp_seen;
  bit   hold_done;

  bbp_req_if #(.PARAM_FRAC_BITS(16)) req_if ();
  bbp_rsp_if                          rsp_if ();

  bicubic_bezier_patch_eval uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  bbp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("[bicubic_bezier_patch_eval] ERROR");
    $finish;
  end

  // gap draw: some stretches have no idling at all
  function automatic int draw_gap(input int n);
    if ((n / 150) % 3 == 1) return 0;
    return $urandom_range(17, 0);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5, 0))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(2000, 0)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(7, 0))
      0: return 17'd65536;
      1: return 17'd0;
      2: return 17'($urandom_range(131071, 65537));
      default: return 17'($urandom_range(65535, 0));
    endcase
  endfunction

  // response side: random stalls, one long hold-off so the block backs up
  initial begin
    int gap;
    bit rdy_seen;
    rsp_if.ready <= 1'b0;
    rsp_seen = 0;
    hold_done = 0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(rsp_seen + 75);
      if (!hold_done && rsp_seen >= 300) begin
        gap = 600;
        hold_done = 1;
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        rdy_seen = rsp_if.valid;
        @(posedge clk_i);
      end while (!rdy_seen);
      rsp_seen++;
    end
  end

  int sent;

  task automatic send_request(input req_type_e kind, input logic [1:0] idx,
                              input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [16:0] pu,
                              input logic [16:0] pv);
    int gap;
    bit acc;
    req_if.req_type    <= kind;
    req_if.point_index <= idx;
    req_if.coord_x     <= cx;
    req_if.coord_y     <= cy;
    req_if.coord_z     <= cz;
    req_if.param_u     <= pu;
    req_if.param_v     <= pv;
    req_if.valid       <= 1'b1;
    do begin
      @(negedge clk_i);
      acc = req_if.ready;
      @(posedge clk_i);
    end while (!acc);
    sent++;
    gap = draw_gap(sent);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_load(input logic [1:0] idx, input logic [31:0] cx,
                           input logic [31:0] cy, input logic [31:0] cz);
    send_request(REQ_LOAD, idx, cx, cy, cz, 17'($urandom), 17'($urandom));
  endtask

  task automatic send_eval(input logic [16:0] pu, input logic [16:0] pv);
    send_request(REQ_EVAL, 2'($urandom), $urandom, $urandom, $urandom, pu, pv);
  endtask

  initial begin
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_LOAD;
    req_if.point_index <= '0;
    req_if.coord_x     <= '0;
    req_if.coord_y     <= '0;
    req_if.coord_z     <= '0;
    req_if.param_u     <= '0;
    req_if.param_v     <= '0;
    sent = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // evaluate the all-zero grid, then corner coordinates on every diagonal slot
    send_eval(17'd32768, 17'd32768);
    send_load(2'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_load(2'd1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_fffe);
    send_load(2'd2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_load(2'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
    send_eval(17'd0, 17'd0);
    send_eval(17'd65536, 17'd65536);
    send_eval(17'd32768, 17'd32768);
    send_eval(17'h1ffff, 17'd0);
    send_eval(17'd65537, 17'h1ffff);
    send_eval(17'd1, 17'd65535);
    // odd z sums with negative values round toward minus infinity
    send_load(2'd0, 32'hffff_ffff, 32'd0, 32'hffff_fffd);
    send_load(2'd1, 32'd0, 32'hffff_ffff, 32'd0);
    send_load(2'd2, 32'd256, 32'hffff_ff00, 32'd7);
    send_load(2'd3, 32'hffff_ffff, 32'd1, 32'hffff_fff8);
    send_eval(17'd21845, 17'd43690);
    send_eval(17'd65536, 17'd0);
    send_eval(17'h15555, 17'h0aaaa);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 1000) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending_cnt != 0) @(posedge clk_i);
      end
      if ($urandom_range(3, 0) == 0)
        send_load(2'($urandom_range(3, 0)), rand_coord(), rand_coord(), rand_coord());
      else
        send_eval(rand_param(), rand_param());
    end
    req_if.valid <= 1'b0;
    @(posedge clk_i);

    while (pending_cnt != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("[bicubic_bezier_patch_eval] OK");
    else
      $display("[bicubic_bezier_patch_eval] ERROR");
    $finish;
  end

endmodule
